FILE: rtl/scurve_threshold_noise_estimator_core_assert.svh
// ----------------------------------------------------------------------------
// S-curve estimator assertion macros
// Concurrent assertion wrappers clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SCURVE_THRESHOLD_NOISE_ESTIMATOR_CORE_ASSERT_SVH
`define SCURVE_THRESHOLD_NOISE_ESTIMATOR_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define STNE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define STNE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define STNE_ASSERT(lbl, prop, msg)
`define STNE_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

FILE: rtl/stne_pkg.sv
// ----------------------------------------------------------------------------
// S-curve estimator package
// Outcome codes and fixed constants shared by the scan, result and top units.
// ----------------------------------------------------------------------------
package stne_pkg;

  typedef enum logic [1:0] {
    OUT_NONE = 2'd0,
    OUT_ONE  = 2'd1,
    OUT_TWO  = 2'd2,
    OUT_FIT  = 2'd3
  } stne_outcome_e;

  localparam int unsigned PLAT_SCALE = 1000;
  localparam int unsigned PLAT_LEVEL = 999;
  localparam int unsigned PCT_SCALE  = 100;
  localparam int unsigned LOW_PCT    = 16;
  localparam int unsigned HIGH_PCT   = 84;

  localparam logic [31:0] INV_SQRT2_Q32 = 32'd3037000500;
  localparam logic [31:0] INV_SQRT6_Q32 = 32'd1753413056;

  localparam int unsigned QSHIFT     = 24;
  localparam int unsigned ROUND_HALF = 8388608;
  localparam int unsigned NOISE_POS_MAX = 65535;
  localparam int unsigned NOISE_NEG_MAX = 65536;

  localparam logic signed [16:0] NOISE_NONE = -17'sd256;

endpackage

FILE: rtl/stne_ram.sv
// ----------------------------------------------------------------------------
// S-curve estimator bin RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module stne_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/stne_scan.sv
// ----------------------------------------------------------------------------
// S-curve estimator curve scanner
// Walks the stored curve once, one bin per cycle, and tracks the start,
// plateau and 16%/84% crossing indices against the last bin's count.
// ----------------------------------------------------------------------------
module stne_scan #(
  parameter int IW = 8,
  parameter int CW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [IW-1:0] lidx_i,
  input  logic [CW-1:0] last_i,
  output logic          rd_en_o,
  output logic [IW-1:0] rd_addr_o,
  input  logic [CW-1:0] rd_data_i,
  output logic          done_o,
  output logic [IW-1:0] first_o,
  output logic [IW-1:0] end_o,
  output logic [IW-1:0] lo16_o,
  output logic [IW-1:0] hi16_o,
  output logic [IW-1:0] lo84_o,
  output logic [IW-1:0] hi84_o
);

  localparam int PW = CW + 10;

  logic          active_q, v_q, done_q;
  logic [IW-1:0] cnt_q, idx_q;
  logic [PW-1:0] l999_q, l16_q, l84_q;
  logic          lzero_q, nz_q, endf_q;
  logic [IW-1:0] first_q, end_q, lo16_q, hi16_q, lo84_q, hi84_q;

  logic [PW-1:0] c1000, c100;

  assign c1000 = PW'(rd_data_i) * PW'(stne_pkg::PLAT_SCALE);
  assign c100  = PW'(rd_data_i) * PW'(stne_pkg::PCT_SCALE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      v_q      <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
      idx_q    <= '0;
    end else begin
      v_q    <= active_q;
      idx_q  <= cnt_q;
      done_q <= v_q && (idx_q == lidx_i);
      if (start_i) begin
        active_q <= 1'b1;
        cnt_q    <= '0;
      end else if (active_q) begin
        cnt_q <= cnt_q + IW'(1);
        if (cnt_q == lidx_i) begin
          active_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      l999_q  <= PW'(last_i) * PW'(stne_pkg::PLAT_LEVEL);
      l16_q   <= PW'(last_i) * PW'(stne_pkg::LOW_PCT);
      l84_q   <= PW'(last_i) * PW'(stne_pkg::HIGH_PCT);
      lzero_q <= (last_i == '0);
      nz_q    <= 1'b0;
      endf_q  <= 1'b0;
      first_q <= '0;
      end_q   <= '0;
      lo16_q  <= '0;
      hi16_q  <= '0;
      lo84_q  <= '0;
      hi84_q  <= '0;
    end else if (v_q) begin
      if (!nz_q && (rd_data_i != '0)) begin
        nz_q    <= 1'b1;
        first_q <= (idx_q == '0) ? '0 : idx_q - IW'(1);
      end
      if (!lzero_q && !endf_q && (c1000 >= l999_q)) begin
        endf_q <= 1'b1;
        end_q  <= idx_q;
      end
      if ((idx_q != '0) && (lo16_q == '0) && (c100 >= l16_q)) begin
        lo16_q <= idx_q;
      end
      if ((idx_q != '0) && (lo84_q == '0) && (c100 >= l84_q)) begin
        lo84_q <= idx_q;
      end
      if (c100 <= l16_q) begin
        hi16_q <= idx_q;
      end
      if (c100 <= l84_q) begin
        hi84_q <= idx_q;
      end
    end
  end

  assign rd_en_o   = active_q;
  assign rd_addr_o = cnt_q;
  assign done_o    = done_q;
  assign first_o   = first_q;
  assign end_o     = lzero_q ? first_q : end_q;
  assign lo16_o    = lo16_q;
  assign hi16_o    = hi16_q;
  assign lo84_o    = lo84_q;
  assign hi84_o    = hi84_q;

endmodule

FILE: rtl/stne_post.sv
// ----------------------------------------------------------------------------
// S-curve estimator result unit
// Classifies the valid span, forms the threshold guess and scales the noise
// guess to Q8.8 through one registered multiply.
// ----------------------------------------------------------------------------
module stne_post #(
  parameter int IW = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [IW-1:0]               first_i,
  input  logic [IW-1:0]               end_i,
  input  logic [IW-1:0]               lo16_i,
  input  logic [IW-1:0]               hi16_i,
  input  logic [IW-1:0]               lo84_i,
  input  logic [IW-1:0]               hi84_i,
  output logic                        done_o,
  output logic [IW-1:0]               first_o,
  output logic [IW-1:0]               end_o,
  output logic [IW-1:0]               slow_o,
  output logic [IW-1:0]               shigh_o,
  output logic [IW:0]                 valid_o,
  output stne_pkg::stne_outcome_e     outcome_o,
  output logic signed [IW+1:0]        thr_o,
  output logic signed [16:0]          noise_o
);

  localparam int TW  = IW + 2;
  localparam int PRW = IW + 32;
  localparam int RW  = (IW + 9 > 18) ? IW + 9 : 18;

  logic [IW-1:0]           ssig, esig, mag;
  logic [IW:0]             valid, dx;
  logic signed [TW-1:0]    thr;
  stne_pkg::stne_outcome_e outcome;
  logic                    neg;
  logic [31:0]             kval;

  logic                    a_v_q, b_v_q;
  logic [IW-1:0]           a_first_q, a_end_q, a_ssig_q, a_esig_q, a_mag_q;
  logic [IW:0]             a_valid_q;
  stne_pkg::stne_outcome_e a_outcome_q;
  logic signed [TW-1:0]    a_thr_q;
  logic                    a_neg_q;
  logic [31:0]             a_k_q;
  logic [IW-1:0]           b_first_q, b_end_q, b_ssig_q, b_esig_q;
  logic [IW:0]             b_valid_q;
  stne_pkg::stne_outcome_e b_outcome_q;
  logic signed [TW-1:0]    b_thr_q;
  logic                    b_neg_q;
  logic [PRW-1:0]          b_prod_q;

  logic [PRW:0]            rnd_sum;
  logic [RW-1:0]           r_ext, lim, mclip;
  logic [16:0]             m17;

  always_comb begin
    ssig = IW'(((IW+1)'(lo16_i) + (IW+1)'(hi16_i)) >> 1);
    esig = IW'(((IW+1)'(lo84_i) + (IW+1)'(hi84_i)) >> 1);
    if ((end_i > first_i) || ((end_i == first_i) && (end_i != '0))) begin
      valid = (IW+1)'(end_i) - (IW+1)'(first_i) + (IW+1)'(1);
    end else begin
      valid = '0;
    end
    dx   = (IW+1)'(esig) - (IW+1)'(ssig);
    neg  = 1'b0;
    mag  = '0;
    kval = stne_pkg::INV_SQRT2_Q32;
    thr  = '1;
    if (valid > (IW+1)'(2)) begin
      outcome = stne_pkg::OUT_FIT;
      thr     = signed'(TW'(first_i) + TW'(valid >> 1));
      neg     = dx[IW];
      mag     = dx[IW] ? IW'(-dx) : IW'(dx);
    end else if (valid == (IW+1)'(2)) begin
      outcome = stne_pkg::OUT_TWO;
      thr     = signed'(TW'(((IW+1)'(first_i) + (IW+1)'(end_i)) >> 1));
      mag     = end_i - first_i;
      kval    = stne_pkg::INV_SQRT6_Q32;
    end else if (valid == (IW+1)'(1)) begin
      outcome = stne_pkg::OUT_ONE;
    end else begin
      outcome = stne_pkg::OUT_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
    end else begin
      a_v_q <= start_i;
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_first_q   <= first_i;
      a_end_q     <= end_i;
      a_ssig_q    <= ssig;
      a_esig_q    <= esig;
      a_valid_q   <= valid;
      a_outcome_q <= outcome;
      a_thr_q     <= thr;
      a_neg_q     <= neg;
      a_mag_q     <= mag;
      a_k_q       <= kval;
    end
    if (a_v_q) begin
      b_first_q   <= a_first_q;
      b_end_q     <= a_end_q;
      b_ssig_q    <= a_ssig_q;
      b_esig_q    <= a_esig_q;
      b_valid_q   <= a_valid_q;
      b_outcome_q <= a_outcome_q;
      b_thr_q     <= a_thr_q;
      b_neg_q     <= a_neg_q;
      b_prod_q    <= PRW'(a_mag_q) * PRW'(a_k_q);
    end
  end

  always_comb begin
    rnd_sum = (PRW+1)'(b_prod_q) + (PRW+1)'(stne_pkg::ROUND_HALF);
    r_ext   = RW'(rnd_sum[PRW:stne_pkg::QSHIFT]);
    lim     = b_neg_q ? RW'(stne_pkg::NOISE_NEG_MAX) : RW'(stne_pkg::NOISE_POS_MAX);
    mclip   = (r_ext > lim) ? lim : r_ext;
    m17     = 17'(mclip);
    if ((b_outcome_q == stne_pkg::OUT_FIT) || (b_outcome_q == stne_pkg::OUT_TWO)) begin
      noise_o = b_neg_q ? signed'(-m17) : signed'(m17);
    end else begin
      noise_o = stne_pkg::NOISE_NONE;
    end
  end

  assign done_o    = b_v_q;
  assign first_o   = b_first_q;
  assign end_o     = b_end_q;
  assign slow_o    = b_ssig_q;
  assign shigh_o   = b_esig_q;
  assign valid_o   = b_valid_q;
  assign outcome_o = b_outcome_q;
  assign thr_o     = b_thr_q;

endmodule

FILE: rtl/scurve_threshold_noise_estimator_core.sv
// ----------------------------------------------------------------------------
// S-curve threshold and noise estimator
// Loads the bin counts of one pixel's S-curve into a bin RAM, then scans the
// stored curve and emits start, plateau, sigma bins, class and first guesses.
//
// Input stream: one beat per bin, in bin order; tdata = {bin_count, pixel_id}.
// After num_bins beats the last beat closes the curve and one result beat
// follows on the output stream. Mid-curve beats produce nothing.
// Loading writes each accepted bin into the RAM. Analysis reads the RAM once per
// bin through its single read port, then passes the scan and result pipeline
// registers on to the output register; the input is held off during analysis
// and while a configuration write is offered, so the next curve loads only once
// the analysis of the last one is done.
// The result sits in an output register: loading of the next curve goes on
// while the receiver stalls, and only the closing bin of the next curve waits
// until the pending result beat is taken.
// Configuration: a write of num_bins restarts loading at bin 0; write only
// while the block is idle. Reset sets num_bins to 256 and the load index to 0;
// the bin RAM needs no clearing since analysis only reads freshly loaded bins.
// ----------------------------------------------------------------------------
module scurve_threshold_noise_estimator_core #(
  parameter int MAX_BINS   = 256,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [8:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] pixel_id, [31:16] bin_count
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] pixel_tag, [23:16] first_bin, [31:24] plateau_bin,
  // [39:32] sigma_low_bin, [47:40] sigma_high_bin, [56:48] valid_bins,
  // [58:57] outcome, [67:59] threshold_guess, [84:68] noise_guess_q8, [87:85] zero
  output logic [87:0] m_axis_tdata
);

  `include "scurve_threshold_noise_estimator_core_assert.svh"

  localparam int IW  = $clog2(MAX_BINS);
  localparam int CW  = COUNT_BITS;
  localparam int CFW = (IW + 1 > 9) ? IW + 1 : 9;
  localparam logic [IW-1:0] LAST_MAX = IW'(MAX_BINS - 1);
  localparam logic [IW-1:0] RST_LIDX = IW'(((MAX_BINS < 256) ? MAX_BINS : 256) - 1);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_POST
  } state_e;

  state_e                  state_q;
  logic [IW-1:0]           load_idx_q, lidx_q, lidx_d;
  logic [CW-1:0]           last_q;
  logic [15:0]             tag_q;
  logic                    scan_start_q;
  logic                    out_v_q;
  logic [15:0]             out_tag_q;
  logic [7:0]              out_first_q, out_end_q, out_slow_q, out_shigh_q;
  logic [8:0]              out_valid_q;
  stne_pkg::stne_outcome_e out_outcome_q;
  logic signed [8:0]       out_thr_q;
  logic signed [16:0]      out_noise_q;

  logic                    in_acc, cfg_acc, out_acc, ram_we;
  logic [CW-1:0]           bin_cnt;
  logic [CFW-1:0]          cfg_num, cfg_num_m1;

  logic                    scan_rd_en, scan_done;
  logic [IW-1:0]           scan_rd_addr;
  logic [CW-1:0]           ram_rdata;
  logic [IW-1:0]           sc_first, sc_end, sc_lo16, sc_hi16, sc_lo84, sc_hi84;

  logic                    post_done;
  logic [IW-1:0]           pt_first, pt_end, pt_slow, pt_shigh;
  logic [IW:0]             pt_valid;
  stne_pkg::stne_outcome_e pt_outcome;
  logic signed [IW+1:0]    pt_thr;
  logic signed [16:0]      pt_noise;

  assign s_axis_tready = (state_q == ST_LOAD) && !cfg_valid_i &&
                         (!out_v_q || (load_idx_q != lidx_q));
  assign cfg_ready_o   = (state_q == ST_LOAD);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_acc       = cfg_valid_i && cfg_ready_o;
  assign out_acc       = out_v_q && m_axis_tready;
  assign ram_we        = in_acc;
  assign bin_cnt       = CW'(s_axis_tdata[31:16]);

  assign cfg_num    = CFW'(cfg_data_i);
  assign cfg_num_m1 = cfg_num - CFW'(1);

  always_comb begin
    priority if (cfg_num == '0) begin
      lidx_d = '0;
    end else if (cfg_num > CFW'(MAX_BINS)) begin
      lidx_d = LAST_MAX;
    end else begin
      lidx_d = cfg_num_m1[IW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_LOAD;
      load_idx_q    <= '0;
      lidx_q        <= RST_LIDX;
      last_q        <= '0;
      tag_q         <= '0;
      scan_start_q  <= 1'b0;
      out_v_q       <= 1'b0;
      out_tag_q     <= '0;
      out_first_q   <= '0;
      out_end_q     <= '0;
      out_slow_q    <= '0;
      out_shigh_q   <= '0;
      out_valid_q   <= '0;
      out_outcome_q <= stne_pkg::OUT_NONE;
      out_thr_q     <= '0;
      out_noise_q   <= '0;
    end else begin
      scan_start_q <= in_acc && (load_idx_q == lidx_q);
      if (out_acc) begin
        out_v_q <= 1'b0;
      end
      unique case (state_q)
        ST_LOAD: begin
          if (cfg_acc) begin
            lidx_q     <= lidx_d;
            load_idx_q <= '0;
          end else if (in_acc) begin
            if (load_idx_q == lidx_q) begin
              load_idx_q   <= '0;
              last_q       <= bin_cnt;
              tag_q        <= s_axis_tdata[15:0];
              state_q      <= ST_SCAN;
            end else begin
              load_idx_q <= load_idx_q + IW'(1);
            end
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            state_q <= ST_POST;
          end
        end
        ST_POST: begin
          if (post_done) begin
            out_v_q       <= 1'b1;
            out_tag_q     <= tag_q;
            out_first_q   <= 8'(pt_first);
            out_end_q     <= 8'(pt_end);
            out_slow_q    <= 8'(pt_slow);
            out_shigh_q   <= 8'(pt_shigh);
            out_valid_q   <= 9'(pt_valid);
            out_outcome_q <= pt_outcome;
            out_thr_q     <= 9'(pt_thr);
            out_noise_q   <= pt_noise;
            state_q       <= ST_LOAD;
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  stne_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_BINS)
  ) u_bin_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (load_idx_q),
    .wdata_i (bin_cnt),
    .re_i    (scan_rd_en),
    .raddr_i (scan_rd_addr),
    .rdata_o (ram_rdata)
  );

  stne_scan #(
    .IW (IW),
    .CW (CW)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (scan_start_q),
    .lidx_i    (lidx_q),
    .last_i    (last_q),
    .rd_en_o   (scan_rd_en),
    .rd_addr_o (scan_rd_addr),
    .rd_data_i (ram_rdata),
    .done_o    (scan_done),
    .first_o   (sc_first),
    .end_o     (sc_end),
    .lo16_o    (sc_lo16),
    .hi16_o    (sc_hi16),
    .lo84_o    (sc_lo84),
    .hi84_o    (sc_hi84)
  );

  stne_post #(
    .IW (IW)
  ) u_post (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (scan_done),
    .first_i   (sc_first),
    .end_i     (sc_end),
    .lo16_i    (sc_lo16),
    .hi16_i    (sc_hi16),
    .lo84_i    (sc_lo84),
    .hi84_i    (sc_hi84),
    .done_o    (post_done),
    .first_o   (pt_first),
    .end_o     (pt_end),
    .slow_o    (pt_slow),
    .shigh_o   (pt_shigh),
    .valid_o   (pt_valid),
    .outcome_o (pt_outcome),
    .thr_o     (pt_thr),
    .noise_o   (pt_noise)
  );

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {3'b000, out_noise_q, out_thr_q, out_outcome_q, out_valid_q,
                          out_shigh_q, out_slow_q, out_end_q, out_first_q, out_tag_q};

  `STNE_ASSERT(a_result_slot_free, post_done |-> !out_v_q, "result overwrites pending beat")
  `STNE_ASSERT(a_ram_port_excl, ram_we |-> !scan_rd_en, "bin load during scan")
  `STNE_ASSERT(a_scan_in_state, scan_done |-> (state_q == ST_SCAN), "scan done out of state")
  `STNE_ASSERT(a_sentinel_pair,
    (out_v_q && (out_outcome_q == stne_pkg::OUT_NONE || out_outcome_q == stne_pkg::OUT_ONE))
      |-> (out_thr_q == '1 && out_noise_q == stne_pkg::NOISE_NONE),
    "sentinels missing for short span")
  `STNE_ASSERT_NEXT(a_close_starts_scan, in_acc && (load_idx_q == lidx_q) && !cfg_acc,
    (state_q == ST_SCAN) && scan_start_q, "closing bin did not start scan")

endmodule

FILE: test/tb_scurve_threshold_noise_estimator_core.sv
// ----------------------------------------------------------------------------
// S-curve threshold and noise estimator testbench
// Streams pixel curves into the core one bin per beat. The bench keeps its own
// copy of the bin store and the curve length, and it works out each pixel's
// estimate when the curve's last bin is taken. It then checks every result
// beat field by field against the oldest pending estimate. The directed curves
// cover empty, flat, one-bin, two-bin, falling and full-scale shapes and a
// reload on a length write. Random S-curves and noise follow under three
// backpressure mixes, and a watchdog guards against a stalled core.
// ----------------------------------------------------------------------------
module tb_scurve_threshold_noise_estimator_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_BINS       = 256;
  localparam int SETTLE_CYCLES  = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic [15:0]             pixel_tag;
    logic [7:0]              first_bin;
    logic [7:0]              plateau_bin;
    logic [7:0]              sigma_low_bin;
    logic [7:0]              sigma_high_bin;
    logic [8:0]              valid_bins;
    stne_pkg::stne_outcome_e outcome;
    logic signed [8:0]       threshold_guess;
    logic signed [16:0]      noise_guess_q8;
  } estimate_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_valid_i    = 1'b0;
  logic        cfg_ready_o;
  logic [8:0]  cfg_data_i     = '0;
  logic        s_axis_tvalid  = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata   = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready  = 1'b0;
  logic [87:0] m_axis_tdata;

  estimate_t   awaited_estimates[$];
  logic [15:0] curve_store [MAX_BINS];
  logic [15:0] curve_shape [MAX_BINS];
  int unsigned load_pos      = 0;
  logic [8:0]  bins_setting  = 9'd256;
  int unsigned items_sent    = 0;
  int unsigned src_idle_pct  = 21;
  int unsigned dst_idle_pct  = 73;
  int unsigned fail_cnt      = 0;
  int unsigned quiet_cycles  = 0;

  scurve_threshold_noise_estimator_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic int curve_len();
    if (bins_setting == 9'd0) return 1;
    if (bins_setting > MAX_BINS) return MAX_BINS;
    return int'(bins_setting);
  endfunction

  function automatic longint scale_noise(longint x, longint unsigned k);
    longint unsigned mag;
    longint r;
    mag = (x < 0) ? -x : x;
    r = longint'((mag * k + stne_pkg::ROUND_HALF) >> stne_pkg::QSHIFT);
    if (x < 0) r = -r;
    if (r > longint'(stne_pkg::NOISE_POS_MAX)) r = longint'(stne_pkg::NOISE_POS_MAX);
    if (r < -longint'(stne_pkg::NOISE_NEG_MAX)) r = -longint'(stne_pkg::NOISE_NEG_MAX);
    return r;
  endfunction

  function automatic estimate_t estimate_curve(logic [15:0] tag, int len);
    estimate_t e;
    longint unsigned lvl, c;
    int start, plat, lo16, lo84, hi16, hi84, sig_lo, sig_hi, valid, thr;
    longint noise;
    bit got_start, got_plat;
    start = 0; plat = 0; lo16 = 0; lo84 = 0; hi16 = 0; hi84 = 0;
    got_start = 1'b0; got_plat = 1'b0;
    lvl = curve_store[len-1];
    for (int i = 0; i < len; i++)
      if (!got_start && curve_store[i] != 16'd0) begin
        start = (i > 0) ? i - 1 : 0;
        got_start = 1'b1;
      end
    for (int i = start; i < len; i++) begin
      c = curve_store[i];
      if (!got_plat && c * stne_pkg::PLAT_SCALE >= lvl * stne_pkg::PLAT_LEVEL) begin
        plat = i;
        got_plat = 1'b1;
      end
    end
    for (int i = 1; i < len; i++) begin
      c = curve_store[i];
      c = c * stne_pkg::PCT_SCALE;
      if (lo16 == 0 && c >= lvl * stne_pkg::LOW_PCT) lo16 = i;
      if (lo84 == 0 && c >= lvl * stne_pkg::HIGH_PCT) lo84 = i;
    end
    for (int i = 0; i < len; i++) begin
      c = curve_store[i];
      c = c * stne_pkg::PCT_SCALE;
      if (c <= lvl * stne_pkg::LOW_PCT) hi16 = i;
      if (c <= lvl * stne_pkg::HIGH_PCT) hi84 = i;
    end
    sig_lo = (lo16 + hi16) >> 1;
    sig_hi = (lo84 + hi84) >> 1;
    if (plat - start > 0 || (plat == start && plat != 0)) valid = plat - start + 1;
    else valid = 0;
    if (valid > 2) begin
      e.outcome = stne_pkg::OUT_FIT;
      thr = start + valid / 2;
      noise = scale_noise(sig_hi - sig_lo, stne_pkg::INV_SQRT2_Q32);
    end else if (valid == 2) begin
      e.outcome = stne_pkg::OUT_TWO;
      thr = (start + plat) / 2;
      noise = scale_noise(plat - start, stne_pkg::INV_SQRT6_Q32);
    end else begin
      e.outcome = (valid == 1) ? stne_pkg::OUT_ONE : stne_pkg::OUT_NONE;
      thr = -1;
      noise = stne_pkg::NOISE_NONE;
    end
    e.pixel_tag       = tag;
    e.first_bin       = 8'(start);
    e.plateau_bin     = 8'(plat);
    e.sigma_low_bin   = 8'(sig_lo);
    e.sigma_high_bin  = 8'(sig_hi);
    e.valid_bins      = 9'(valid);
    e.threshold_guess = 9'(thr);
    e.noise_guess_q8  = 17'(noise);
    return e;
  endfunction

  function automatic void load_bin(logic [15:0] pid, logic [15:0] cnt);
    if (load_pos >= MAX_BINS) load_pos = 0;
    curve_store[load_pos] = cnt;
    load_pos++;
    if (load_pos >= curve_len()) begin
      load_pos = 0;
      awaited_estimates.push_back(estimate_curve(pid, curve_len()));
    end
  endfunction

  function automatic void check_field(string name, logic signed [63:0] want,
                                      logic signed [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endfunction

  task automatic push_bin(input logic [15:0] pid, input logic [15:0] cnt);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {cnt, pid};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    load_bin(pid, cnt);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (awaited_estimates.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_num_bins(input logic [8:0] value);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    bins_setting = value;
    load_pos = 0;
  endtask

  task automatic send_curve(input int len, input logic [15:0] pid, input bit scatter);
    for (int i = 0; i < len; i++)
      push_bin(scatter ? 16'($urandom_range(65535)) : pid, curve_shape[i]);
  endtask

  task automatic send_fixed(input logic [15:0] pid, input logic [15:0] vals[$]);
    foreach (vals[i]) push_bin(pid, vals[i]);
  endtask

  function automatic void make_curve(int len);
    int kind, r0, w;
    longint unsigned lvl, v;
    kind = $urandom_range(9);
    case ($urandom_range(3))
      0: lvl = $urandom_range(65535);
      1: lvl = 65535 - $urandom_range(100);
      2: lvl = $urandom_range(200, 1);
      default: lvl = $urandom_range(60000, 1000);
    endcase
    r0 = $urandom_range(len);
    w  = $urandom_range(len, 1);
    for (int i = 0; i < len; i++) begin
      if (kind <= 6) begin
        if (i < r0) v = 0;
        else if (i < r0 + w) v = lvl * longint'(i - r0 + 1) / longint'(w);
        else v = lvl;
        if (v > 2 && $urandom_range(5) == 0) v = v - $urandom_range(2);
      end else if (kind == 7) begin
        v = $urandom_range(65535);
      end else if (kind == 8) begin
        v = ($urandom_range(4) == 0) ? $urandom_range(65535) : 0;
      end else begin
        v = lvl * longint'(len - i) / longint'(len);
      end
      curve_shape[i] = 16'(v);
    end
  endfunction

  function automatic logic [8:0] pick_setting();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 4) return 9'd0;
    if (r < 10) return 9'($urandom_range(48, 17));
    return 9'($urandom_range(16, 1));
  endfunction

  task automatic test_default_size();
    make_curve(curve_len());
    send_curve(curve_len(), 16'h1234, 1'b0);
  endtask

  task automatic test_empty_curve();
    write_num_bins(9'd4);
    send_fixed(16'h0001, '{16'd0, 16'd0, 16'd0, 16'd0});
  endtask

  task automatic test_two_bin_and_one_bin();
    write_num_bins(9'd3);
    send_fixed(16'h0002, '{16'd0, 16'd100, 16'd100});
    write_num_bins(9'd4);
    send_fixed(16'h0003, '{16'd0, 16'd0, 16'd7, 16'd0});
  endtask

  task automatic test_count_extremes();
    write_num_bins(9'd5);
    send_fixed(16'hFFFF, '{16'd0, 16'd1, 16'd32768, 16'd65534, 16'd65535});
    send_fixed(16'h0000, '{16'd65535, 16'd40000, 16'd1000, 16'd0, 16'd20});
  endtask

  task automatic test_reload_on_write();
    write_num_bins(9'd5);
    send_fixed(16'h0004, '{16'd65535, 16'd65535});
    write_num_bins(9'd3);
    send_fixed(16'h0005, '{16'd5, 16'd5, 16'd5});
  endtask

  task automatic test_single_bin();
    write_num_bins(9'd0);
    send_fixed(16'h0006, '{16'd0, 16'd65535});
  endtask

  task automatic test_oversize_setting();
    write_num_bins(9'd511);
    make_curve(curve_len());
    send_curve(curve_len(), 16'hA5A5, 1'b0);
  endtask

  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned stop_at;
    int len, cut;
    stop_at = items_sent + n_items;
    write_num_bins(pick_setting());
    while (items_sent < stop_at) begin
      if ($urandom_range(3) == 0) write_num_bins(pick_setting());
      len = curve_len();
      make_curve(len);
      if (len > 1 && $urandom_range(11) == 0) begin
        cut = $urandom_range(len - 1, 1);
        send_curve(cut, 16'($urandom_range(65535)), 1'b0);
        write_num_bins(pick_setting());
      end else begin
        send_curve(len, 16'($urandom_range(65535)), $urandom_range(9) == 0);
        if ($urandom_range(7) == 0) drain();
      end
    end
  endtask

  always @(posedge clk_i) begin : result_check
    estimate_t want;
    m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_estimates.size() == 0) begin
        $error("result beat with no pending estimate: %h", m_axis_tdata);
        fail_cnt++;
      end else begin
        want = awaited_estimates.pop_front();
        check_field("pixel_tag", want.pixel_tag, m_axis_tdata[15:0]);
        check_field("first_bin", want.first_bin, m_axis_tdata[23:16]);
        check_field("plateau_bin", want.plateau_bin, m_axis_tdata[31:24]);
        check_field("sigma_low_bin", want.sigma_low_bin, m_axis_tdata[39:32]);
        check_field("sigma_high_bin", want.sigma_high_bin, m_axis_tdata[47:40]);
        check_field("valid_bins", want.valid_bins, m_axis_tdata[56:48]);
        check_field("outcome", want.outcome, m_axis_tdata[58:57]);
        check_field("threshold_guess", want.threshold_guess,
                    $signed(m_axis_tdata[67:59]));
        check_field("noise_guess_q8", want.noise_guess_q8,
                    $signed(m_axis_tdata[84:68]));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL scurve_threshold_noise_estimator_core");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_size();
    test_empty_curve();
    test_two_bin_and_one_bin();
    test_count_extremes();
    test_reload_on_write();
    test_single_bin();
    test_oversize_setting();
    test_random_traffic(180);
    src_idle_pct = 73;
    dst_idle_pct = 21;
    test_random_traffic(180);
    src_idle_pct = 0;
    dst_idle_pct = 0;
    test_random_traffic(180);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (awaited_estimates.size() != 0) begin
      $error("%0d estimates never arrived", awaited_estimates.size());
      fail_cnt++;
    end
    if (fail_cnt == 0)
      $display("PASS scurve_threshold_noise_estimator_core");
    else
      $display("FAIL scurve_threshold_noise_estimator_core");
    $finish;
  end

endmodule
